// ===== src/ppb_pkg.sv =====
// Shared types, codes and constants of the pilot protection blocking logic.
package ppb_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MIX_GAIN      = 2'd0,
        CFG_UNBLOCK_TICKS = 2'd1,
        CFG_REBLOCK_TICKS = 2'd2
    } cfg_idx_t;

    // Received frame kinds.
    typedef enum logic [1:0] {
        RX_NONE     = 2'd0,
        RX_NUMBERED = 2'd1,
        RX_LEGACY   = 2'd2
    } rx_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAC_LO,
        ST_MAC_HI,
        ST_FINISH
    } ppb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic prep;
        logic mac_lo;
        logic mac_hi;
        logic commit;
    } ppb_cmd_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // sqrt(3)/2 in Q16.
    localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;

endpackage

// ===== src/ppb_sample_if.sv =====
// Input sample channel: valid, ready and the sample fields.
interface ppb_sample_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] phase_a_re;
    logic signed [23:0] phase_b_re;
    logic signed [23:0] phase_b_im;
    logic signed [23:0] phase_c_re;
    logic signed [23:0] phase_c_im;
    logic [31:0]        now_tick;
    logic [1:0]         rx_kind;
    logic [31:0]        rx_seq;
    logic [7:0]         rx_byte;

    modport source (
        output valid, phase_a_re, phase_b_re, phase_b_im, phase_c_re, phase_c_im,
               now_tick, rx_kind, rx_seq, rx_byte,
        input  ready
    );

    modport sink (
        input  valid, phase_a_re, phase_b_re, phase_b_im, phase_c_re, phase_c_im,
               now_tick, rx_kind, rx_seq, rx_byte,
        output ready
    );
endinterface

// ===== src/ppb_result_if.sv =====
// Result channel: valid, ready and the result fields.
interface ppb_result_if;
    logic               valid;
    logic               ready;
    logic               blocked;
    logic               local_disc;
    logic [31:0]        tx_seq;
    logic               or_disc;
    logic               gap_seen;
    logic signed [31:0] mixed_current;

    modport source (
        output valid, blocked, local_disc, tx_seq, or_disc, gap_seen, mixed_current,
        input  ready
    );

    modport sink (
        input  valid, blocked, local_disc, tx_seq, or_disc, gap_seen, mixed_current,
        output ready
    );
endinterface

// ===== src/ppb_ctrl.sv =====
// Controller state machine: sequences capture, multiply steps and commit.
module ppb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    output ppb_pkg::ppb_cmd_t cmd
);
    import ppb_pkg::*;

    ppb_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        can_commit = !out_valid_reg || out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MAC_LO;
            end
            ST_MAC_LO:
            begin
                cmd.mac_lo = 1'b1;
                state_next = ST_MAC_HI;
            end
            ST_MAC_HI:
            begin
                cmd.mac_hi = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // The next sample is taken in the same cycle the result is committed.
                if (can_commit)
                begin
                    cmd.commit = 1'b1;
                    in_ready   = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_PREP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/ppb_datapath.sv =====
// Datapath: config registers, shared multiplier, accumulator and blocking state.
module ppb_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ppb_pkg::ppb_cmd_t                cmd,
    input  logic                             cfg_we,
    input  logic [ppb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    ppb_sample_if.sink                       sample,
    ppb_result_if.source                     result
);
    import ppb_pkg::*;

    // Configuration.
    logic signed [15:0] mix_gain_reg;
    logic [31:0]        unblock_ticks_reg;
    logic [31:0]        reblock_ticks_reg;

    // Captured sample.
    logic [31:0]        now_reg;
    logic [1:0]         kind_reg;
    logic [31:0]        seq_reg;
    logic [7:0]         byte_reg;
    logic signed [26:0] a2_reg;
    logic signed [42:0] quad_reg;
    logic signed [43:0] neg3_reg;
    logic signed [63:0] acc_reg;

    // Protection state.
    logic [31:0] last_rx_reg, last_rx_next;
    logic        remote_reg, remote_next;
    logic        zero_active_reg, zero_active_next;
    logic        one_active_reg, one_active_next;
    logic [31:0] zero_start_reg, zero_start_next;
    logic [31:0] one_start_reg, one_start_next;
    logic        block_reg, block_next;
    logic [31:0] tx_counter_reg;

    // Result fields that follow the accumulator.
    logic               local_out_reg;
    logic               or_out_reg;
    logic               gap_out_reg;
    logic signed [31:0] mixed_out_reg;

    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] mul_p;

    logic        local_c;
    logic        ord_c;
    logic        gap_c;
    logic [31:0] zero_elapsed;
    logic [31:0] one_elapsed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_gain_reg      <= '0;
            unblock_ticks_reg <= '0;
            reblock_ticks_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIX_GAIN:      mix_gain_reg      <= $signed(cfg_wdata[15:0]);
                CFG_UNBLOCK_TICKS: unblock_ticks_reg <= cfg_wdata;
                CFG_REBLOCK_TICKS: reblock_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // One 25x18 multiplier: the quadrature term at capture, then the gain
    // times the low and high halves of the negative-sequence term.
    always_comb
    begin
        mul_a = 25'(sample.phase_c_im) - 25'(sample.phase_b_im);
        mul_b = SQRT3_HALF_Q16;
        if (cmd.mac_lo)
        begin
            mul_a = $signed({3'b000, neg3_reg[21:0]});
            mul_b = 18'(mix_gain_reg);
        end
        else if (cmd.mac_hi)
        begin
            mul_a = 25'($signed(neg3_reg[43:22]));
            mul_b = 18'(mix_gain_reg);
        end
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg  <= sample.now_tick;
            kind_reg <= sample.rx_kind;
            seq_reg  <= sample.rx_seq;
            byte_reg <= sample.rx_byte;
            quad_reg <= mul_p;
            a2_reg   <= (27'(sample.phase_a_re) <<< 1) - 27'(sample.phase_b_re)
                        - 27'(sample.phase_c_re);
        end
        if (cmd.prep)
        begin
            neg3_reg <= (44'(a2_reg) <<< 15) - 44'(quad_reg);
            acc_reg  <= (64'(a2_reg) <<< 27) + (64'(quad_reg) <<< 12);
        end
        if (cmd.mac_lo)
            acc_reg <= acc_reg + 64'(mul_p);
        if (cmd.mac_hi)
            acc_reg <= acc_reg + (64'(mul_p) <<< 22);
        if (cmd.commit)
        begin
            local_out_reg <= local_c;
            or_out_reg    <= ord_c;
            gap_out_reg   <= gap_c;
            mixed_out_reg <= acc_reg[59:28];
        end
    end

    always_comb
    begin
        local_c      = !acc_reg[63] && (acc_reg != '0);
        last_rx_next = last_rx_reg;
        remote_next  = remote_reg;
        gap_c        = 1'b0;
        unique case (kind_reg)
            RX_NUMBERED:
            begin
                last_rx_next = seq_reg;
                remote_next  = byte_reg != '0;
                gap_c        = (last_rx_reg != '0) && (seq_reg != last_rx_reg + 32'd1);
            end
            RX_LEGACY:
            begin
                // A legacy frame resets numbering, so the next numbered frame is no gap.
                last_rx_next = '0;
                remote_next  = byte_reg != '0;
            end
            default: ;
        endcase
        ord_c = local_c || remote_next;

        // A run that starts on this sample has zero elapsed ticks.
        zero_elapsed = zero_active_reg ? (now_reg - zero_start_reg) : '0;
        one_elapsed  = one_active_reg ? (now_reg - one_start_reg) : '0;

        zero_active_next = zero_active_reg;
        one_active_next  = one_active_reg;
        zero_start_next  = zero_start_reg;
        one_start_next   = one_start_reg;
        block_next       = block_reg;
        if (gap_c)
        begin
            block_next       = 1'b1;
            zero_active_next = 1'b0;
            one_active_next  = 1'b0;
        end
        else if (!ord_c)
        begin
            one_active_next  = 1'b0;
            zero_active_next = 1'b1;
            if (!zero_active_reg)
                zero_start_next = now_reg;
            if (zero_elapsed >= unblock_ticks_reg)
                block_next = 1'b0;
        end
        else
        begin
            zero_active_next = 1'b0;
            one_active_next  = 1'b1;
            if (!one_active_reg)
                one_start_next = now_reg;
            if (one_elapsed >= reblock_ticks_reg)
                block_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rx_reg     <= '0;
            remote_reg      <= 1'b0;
            zero_active_reg <= 1'b0;
            one_active_reg  <= 1'b0;
            zero_start_reg  <= '0;
            one_start_reg   <= '0;
            block_reg       <= 1'b1;
            tx_counter_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            last_rx_reg     <= last_rx_next;
            remote_reg      <= remote_next;
            zero_active_reg <= zero_active_next;
            one_active_reg  <= one_active_next;
            zero_start_reg  <= zero_start_next;
            one_start_reg   <= one_start_next;
            block_reg       <= block_next;
            tx_counter_reg  <= tx_counter_reg + 32'd1;
        end
    end

    // State changes only at commit, so it holds while the result waits.
    assign result.blocked       = block_reg;
    assign result.tx_seq        = tx_counter_reg;
    assign result.local_disc    = local_out_reg;
    assign result.or_disc       = or_out_reg;
    assign result.gap_seen      = gap_out_reg;
    assign result.mixed_current = mixed_out_reg;

endmodule

// ===== src/pilot_protection_block_logic_top.sv =====
// Top level of the pilot protection blocking logic.
//
//  channel   kind            beat contents
//  -------   -------------   ------------------------------------------------
//  sample    valid/ready in  phasor parts, now_tick, received peer frame
//  result    valid/ready out blocked, discriminators, tx_seq, gap, mixed current
//  cfg       write only      cfg_we, cfg_index, cfg_wdata
//
// A sample goes through its beat, then prep, two multiply-accumulate steps
// and commit; the next beat is taken in the commit cycle, so a new sample is
// taken only once the last one commits. The single 25x18 multiplier sets this
// pace: it is used once at the beat and twice more on the gain product.
// Reset is asynchronous; the block comes out of it blocked with no clearing pass.
// A result waiting on the output holds the commit, and with it the next beat.
module pilot_protection_block_logic_top (
    input  logic                             clk,
    input  logic                             rst_n,
    ppb_sample_if.sink                       sample,
    ppb_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [ppb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ppb_pkg::*;

    ppb_cmd_t cmd;
    logic     in_ready;
    logic     out_valid;

    ppb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (in_ready),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    ppb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample),
        .result    (result)
    );

    assign sample.ready = in_ready;
    assign result.valid = out_valid;

endmodule
